// ===== rtl/kuf_pkg.sv =====
// Shared types and constants for the union-find spanning-tree edge filter.
// Used by kuf_ctrl, kuf_datapath and the top level kruskal_union_find_edge_filter.
package kuf_pkg;

  // Field widths
  localparam int unsigned VTX_W   = 11;
  localparam int unsigned WGT_W   = 16;
  // Epoch tag stored next to each parent entry; a wrap forces a clearing sweep
  localparam int unsigned EPOCH_W = 4;

  // Default forest capacity
  localparam int unsigned DEF_MAX_NODES = 1024;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic        REG_NODE_COUNT = 1'b0;
  localparam logic [VTX_W-1:0] NODE_COUNT_RST = 11'd1024;

  // One edge as it arrives
  typedef struct packed {
    logic             restart;
    logic [VTX_W-1:0] endpoint_a;
    logic [VTX_W-1:0] endpoint_b;
    logic [WGT_W-1:0] weight;
  } kuf_in_t;

  // One verdict as it leaves
  typedef struct packed {
    logic             accepted;
    logic [VTX_W-1:0] vertex_low;
    logic [VTX_W-1:0] vertex_high;
    logic [WGT_W-1:0] edge_weight;
    logic             tree_complete;
    logic             bad_endpoint;
  } kuf_out_t;

  // Read address source for the parent memory
  typedef enum logic [1:0] {
    RD_A,
    RD_B,
    RD_PARENT
  } kuf_rd_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic        load_item;
    logic        check;
    logic        clear;
    logic        rd_en;
    kuf_rd_sel_e rd_sel;
    logic        cap_root;
    logic        link;
    logic        load_out;
  } kuf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic wrap;
    logic go;
    logic at_root;
  } kuf_sts_t;

endpackage

// ===== rtl/kruskal_union_find_edge_filter.sv =====
// Top level of the union-find spanning-tree edge filter: config register,
// controller and datapath. Depends on kuf_pkg, kuf_ctrl and kuf_datapath.
//
//   channel   direction  handshake                   payload
//   in        input      in_valid_i / in_stall_o     in_data_i  (kuf_in_t)
//   out       output     out_valid_o / out_stall_i   out_data_o (kuf_out_t)
//   config    input      psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// An eligible edge walks from each endpoint to its root, one parent link at a time,
// through the single read port; a rejected or out-of-range edge skips both walks.
// After reset a sweep over all MAX_NODES entries initializes the parent memory;
// every 16th restart repeats that sweep when the epoch tag wraps.
// A finished result waits in the output register while the next edge transfers.
module kruskal_union_find_edge_filter
  import kuf_pkg::*;
#(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kuf_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kuf_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [VTX_W-1:0] node_count_q;
  kuf_cmd_t         cmd;
  kuf_sts_t         sts;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
      node_count_q <= pwdata[VTX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? DATA_W'(node_count_q) : '0;

  kuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kuf_datapath #(
    .MAX_NODES(MAX_NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .node_count_i(node_count_q),
    .out_data_o  (out_data_o)
  );

  // An accepted edge never carries a bad endpoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |-> !out_data_o.bad_endpoint)
    else $error("accepted edge flagged with bad endpoint");

  // A self loop is never accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.accepted |->
      (out_data_o.vertex_low != out_data_o.vertex_high))
    else $error("self loop accepted");

  // Endpoints leave ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.vertex_low <= out_data_o.vertex_high))
    else $error("endpoints out of order");

  // A transferred edge is not taken again in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second edge taken while one is in work");

endmodule

// ===== rtl/kuf_datapath.sv =====
// Datapath of the edge filter: item registers, parent memory with epoch tags,
// root walk, link write and result register. Depends on kuf_pkg.
module kuf_datapath
  import kuf_pkg::*;
#(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kuf_cmd_t         cmd_i,
  output kuf_sts_t         sts_o,
  input  kuf_in_t          in_data_i,
  input  logic [VTX_W-1:0] node_count_i,
  output kuf_out_t         out_data_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_NODES);
  localparam int unsigned ENT_W  = EPOCH_W + IDX_W;
  localparam int unsigned SAT_N  = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
  localparam logic [VTX_W-1:0] SatN = VTX_W'(SAT_N);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_NODES - 1);

  // Parent memory: {epoch, parent}
  logic [ENT_W-1:0] parent_mem [MAX_NODES];

  kuf_in_t            item_q;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [VTX_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   clr_q;
  logic               bad_q, go_q, acc_q;
  logic [IDX_W-1:0]   root_a_q;
  logic [ENT_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]   rd_idx_q;
  kuf_out_t           out_q;

  logic [VTX_W-1:0]   n_eff, limit;
  logic [VTX_W-1:0]   a_m1, b_m1;
  logic [VTX_W-1:0]   count_eff;
  logic               bad;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   parent;
  logic               at_root;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;

  // Saturate vertex count and derive the edge limit
  always_comb begin
    n_eff = (node_count_i > SatN) ? SatN : node_count_i;
    limit = (n_eff == '0) ? '0 : n_eff - VTX_W'(1);
  end

  // Endpoint range check and eligibility of the held edge
  always_comb begin
    a_m1      = item_q.endpoint_a - VTX_W'(1);
    b_m1      = item_q.endpoint_b - VTX_W'(1);
    bad       = (item_q.endpoint_a == '0) || (item_q.endpoint_a > n_eff) ||
                (item_q.endpoint_b == '0) || (item_q.endpoint_b > n_eff);
    count_eff = item_q.restart ? '0 : count_q;
  end

  // Parent of the entry just read; a stale epoch means the entry is its own root
  always_comb begin
    parent  = (rd_data_q[ENT_W-1 -: EPOCH_W] == epoch_q) ?
              rd_data_q[IDX_W-1:0] : rd_idx_q;
    at_root = (parent == rd_idx_q);
  end

  // Read address select
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_A:      rd_addr = IDX_W'(a_m1);
      RD_B:      rd_addr = IDX_W'(b_m1);
      RD_PARENT: rd_addr = parent;
      default:   rd_addr = parent;
    endcase
  end

  // Write port: clearing sweep or root link
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = {{EPOCH_W{1'b0}}, clr_q};
    if (cmd_i.clear) begin
      wr_en = 1'b1;
    end else if (cmd_i.link && (root_a_q != rd_idx_q)) begin
      wr_en   = 1'b1;
      wr_addr = root_a_q;
      wr_data = {epoch_q, rd_idx_q};
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      parent_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= parent_mem[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  // Epoch and accepted count
  always_comb begin
    epoch_d = epoch_q;
    count_d = count_q;
    if (cmd_i.check && item_q.restart) begin
      epoch_d = epoch_q + EPOCH_W'(1);
      count_d = '0;
    end else if (cmd_i.link && (root_a_q != rd_idx_q)) begin
      count_d = count_q + VTX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0;
      count_q <= '0;
      clr_q   <= '0;
    end else begin
      epoch_q <= epoch_d;
      count_q <= count_d;
      if (cmd_i.clear) begin
        clr_q <= (clr_q == LastIdx) ? '0 : clr_q + IDX_W'(1);
      end
    end
  end

  // Item, verdict and root registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.check) begin
      bad_q <= bad;
      go_q  <= !bad && (count_eff < limit);
      acc_q <= 1'b0;
    end
    if (cmd_i.cap_root) begin
      root_a_q <= rd_idx_q;
    end
    if (cmd_i.link) begin
      acc_q <= (root_a_q != rd_idx_q);
    end
    if (cmd_i.load_out) begin
      out_q.accepted      <= acc_q;
      out_q.vertex_low    <= (item_q.endpoint_a < item_q.endpoint_b) ?
                             item_q.endpoint_a : item_q.endpoint_b;
      out_q.vertex_high   <= (item_q.endpoint_a < item_q.endpoint_b) ?
                             item_q.endpoint_b : item_q.endpoint_a;
      out_q.edge_weight   <= item_q.weight;
      out_q.tree_complete <= (count_q >= limit);
      out_q.bad_endpoint  <= bad_q;
    end
  end

  // Status back to the controller
  always_comb begin
    sts_o.clr_last = (clr_q == LastIdx);
    sts_o.wrap     = item_q.restart && (epoch_q == {EPOCH_W{1'b1}});
    sts_o.go       = go_q;
    sts_o.at_root  = at_root;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/kuf_ctrl.sv =====
// Controller of the edge filter: sequences sweep, check, both root walks,
// link and result hand-off. Depends on kuf_pkg.
module kuf_ctrl
  import kuf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  kuf_sts_t sts_i,
  output kuf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_INIT_SWEEP,
    S_IDLE,
    S_CHECK,
    S_RESTART_SWEEP,
    S_DECIDE,
    S_WALK_A,
    S_WALK_B,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Commands and next state
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_PARENT;
    state_d      = state_q;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      S_INIT_SWEEP: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.wrap ? S_RESTART_SWEEP : S_DECIDE;
      end
      S_RESTART_SWEEP: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.go) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_A;
          state_d      = S_WALK_A;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_WALK_A: begin
        // Follow parent links; at the root, start the second walk
        cmd_o.rd_en = 1'b1;
        if (sts_i.at_root) begin
          cmd_o.cap_root = 1'b1;
          cmd_o.rd_sel   = RD_B;
          state_d        = S_WALK_B;
        end
      end
      S_WALK_B: begin
        if (sts_i.at_root) begin
          cmd_o.link = 1'b1;
          state_d    = S_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
